/* src/hduart_pkg.sv */
`default_nettype none

package hduart_pkg;

    localparam int MAX_FRAME   = 32;
    localparam int FRAME_IDX_W = $clog2(MAX_FRAME);
    localparam int FRAME_CNT_W = $clog2(MAX_FRAME + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_DIVISOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIRE_MODE   = 2'd2;

    localparam logic [15:0] BAUD_DIVISOR_RESET = 16'd417;
    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd5;
    localparam logic [15:0] IDLE_COUNT_MAX     = 16'hFFFF;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_POLL = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;

    localparam logic [3:0] RX_SAMPLES = 4'd9;
    localparam logic [3:0] PHASE_STOP = 4'd9;
    localparam logic [7:0] RX_MSB     = 8'h80;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_POLL,
        OP_LOAD,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [1:0] func;
        logic       rx_level;
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_in_item;

    typedef struct packed {
        logic       tx_level;
        logic       tx_drive;
        logic       busy_res;
        logic       frame_valid;
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic       rx_level;
        logic [7:0] tx_byte;
        logic       tx_last;
    } t_cmd;

endpackage

`default_nettype wire

/* src/half_duplex_uart_frame_engine_core.sv */
// tick, poll and unused codes: status registered as the item is taken; a dumping poll gives none
// load while idle: S_LOAD_WAIT1 and S_LOAD_WAIT2 follow, for the transmit buffer read to settle
// frame dump: S_DUMP_RD then S_DUMP_OUT per byte, for the registered receive buffer read
// a two-item queue sits between input decode and the engine
// reset: synchronous, active low; clears control state, buffers are not cleared
`default_nettype none

module half_duplex_uart_frame_engine_core #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [hduart_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hduart_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire hduart_pkg::t_in_item                i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output hduart_pkg::t_out_item                    o_out_item
);

    logic             cmd_valid;
    logic             cmd_pop;
    hduart_pkg::t_cmd cmd;

    hduart_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    hduart_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("engine took an item from an empty queue");

    a_line_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.busy_res) |-> o_out_item.tx_level)
        else $error("transmit line low while not transmitting");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.frame_valid) |->
        (o_out_item.frame_byte == 8'd0 && !o_out_item.frame_last))
        else $error("status item carries frame fields");

endmodule

`default_nettype wire

/* src/hduart_ram.sv */
`default_nettype none

module hduart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/hduart_front.sv */
`default_nettype none

module hduart_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire hduart_pkg::t_in_item i_in_item,
    output logic                     o_cmd_valid,
    output hduart_pkg::t_cmd         o_cmd,
    input  wire logic                i_cmd_pop
);

    hduart_pkg::t_cmd r_q [2];
    hduart_pkg::t_cmd cmd_in;
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             push;
    logic             pop;

    // decode the function code once, on entry
    always_comb begin
        cmd_in.rx_level = i_in_item.rx_level;
        cmd_in.tx_byte  = i_in_item.tx_byte;
        cmd_in.tx_last  = i_in_item.tx_last;
        case (i_in_item.func)
            hduart_pkg::FUNC_TICK: cmd_in.op = hduart_pkg::OP_TICK;
            hduart_pkg::FUNC_POLL: cmd_in.op = hduart_pkg::OP_POLL;
            hduart_pkg::FUNC_LOAD: cmd_in.op = hduart_pkg::OP_LOAD;
            default:               cmd_in.op = hduart_pkg::OP_NOP;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* src/hduart_back.sv */
`default_nettype none

module hduart_back #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [hduart_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hduart_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                i_cmd_valid,
    input  wire hduart_pkg::t_cmd                    i_cmd,
    output logic                                     o_cmd_pop,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output hduart_pkg::t_out_item                    o_out_item
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AW-1:0] RX_LAST_SLOT = AW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] TX_FULL      = CW'(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        S_RUN,
        S_LOAD_WAIT1,
        S_LOAD_WAIT2,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_baud, n_baud;
    logic [15:0] r_timeout, n_timeout;
    logic        r_one_wire, n_one_wire;

    logic [CW-1:0] r_tx_count, n_tx_count;
    logic [CW-1:0] r_tx_index, n_tx_index;
    logic [3:0]    r_tx_phase, n_tx_phase;
    logic [7:0]    r_tx_shift, n_tx_shift;
    logic          r_tx_on, n_tx_on;
    logic [AW-1:0] r_rx_count, n_rx_count;
    logic [3:0]    r_rx_bits, n_rx_bits;
    logic [7:0]    r_rx_shift, n_rx_shift;
    logic [15:0]   r_idle, n_idle;
    logic [15:0]   r_baud_cnt, n_baud_cnt;
    logic          r_timer_on, n_timer_on;
    logic          r_prev_rx, n_prev_rx;
    logic          r_line, n_line;

    logic [hduart_pkg::FRAME_IDX_W-1:0] r_dump_idx, n_dump_idx;
    logic [hduart_pkg::FRAME_CNT_W-1:0] r_dump_n, n_dump_n;

    logic                  r_out_valid, n_out_valid;
    hduart_pkg::t_out_item r_out_item, n_out_item;

    logic          out_free;
    logic          emit_status;
    logic [15:0]   baud_inc;
    logic [3:0]    rx_bits_dec;
    logic          tx_we;
    logic          rx_we;
    logic [7:0]    tx_rdata;
    logic [7:0]    rx_rdata;
    logic [7:0]    rx_wdata;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_baud      = r_baud;
        n_timeout   = r_timeout;
        n_one_wire  = r_one_wire;
        n_tx_count  = r_tx_count;
        n_tx_index  = r_tx_index;
        n_tx_phase  = r_tx_phase;
        n_tx_shift  = r_tx_shift;
        n_tx_on     = r_tx_on;
        n_rx_count  = r_rx_count;
        n_rx_bits   = r_rx_bits;
        n_rx_shift  = r_rx_shift;
        n_idle      = r_idle;
        n_baud_cnt  = r_baud_cnt;
        n_timer_on  = r_timer_on;
        n_prev_rx   = r_prev_rx;
        n_line      = r_line;
        n_dump_idx  = r_dump_idx;
        n_dump_n    = r_dump_n;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        o_cmd_pop   = 1'b0;
        emit_status = 1'b0;
        baud_inc    = r_baud_cnt + 16'd1;
        rx_bits_dec = (r_rx_bits != 4'd0) ? (r_rx_bits - 4'd1) : 4'd0;
        tx_we       = 1'b0;
        rx_we       = 1'b0;
        rx_wdata    = {i_cmd.rx_level, r_rx_shift[7:1]};

        if (i_cfg_we) begin
            case (i_cfg_idx)
                hduart_pkg::CFG_BAUD_DIVISOR:    n_baud     = i_cfg_data;
                hduart_pkg::CFG_IDLE_TIMEOUT_MS: n_timeout  = i_cfg_data;
                hduart_pkg::CFG_ONE_WIRE_MODE:   n_one_wire = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            S_RUN: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop   = 1'b1;
                    emit_status = 1'b1;
                    case (i_cmd.op)
                        hduart_pkg::OP_TICK: begin
                            if (r_timer_on) begin
                                if (baud_inc >= r_baud) begin
                                    n_baud_cnt = 16'd0;
                                    if (r_tx_on) begin
                                        if (r_tx_phase == 4'd0) begin
                                            // start bit, fetch next byte
                                            n_line     = 1'b0;
                                            n_tx_shift = tx_rdata;
                                            n_tx_index = r_tx_index + CW'(1);
                                            n_tx_phase = 4'd1;
                                        end else if (r_tx_phase < hduart_pkg::PHASE_STOP) begin
                                            n_line     = r_tx_shift[0];
                                            n_tx_shift = {1'b0, r_tx_shift[7:1]};
                                            n_tx_phase = r_tx_phase + 4'd1;
                                        end else begin
                                            // stop bit
                                            n_line     = 1'b1;
                                            n_tx_phase = 4'd0;
                                            if (r_tx_index >= r_tx_count) begin
                                                n_tx_on    = 1'b0;
                                                n_timer_on = 1'b0;
                                                n_tx_count = '0;
                                                n_tx_index = '0;
                                            end
                                        end
                                    end else begin
                                        n_rx_shift = rx_wdata;
                                        n_rx_bits  = rx_bits_dec;
                                        if (rx_bits_dec == 4'd0) begin
                                            n_timer_on = 1'b0;
                                            n_idle     = 16'd0;
                                            rx_we      = 1'b1;
                                            n_rx_count = (r_rx_count == RX_LAST_SLOT) ?
                                                         '0 : (r_rx_count + AW'(1));
                                        end
                                    end
                                end else begin
                                    n_baud_cnt = baud_inc;
                                end
                            end else if (!r_tx_on && r_rx_bits == 4'd0 && r_prev_rx &&
                                         !i_cmd.rx_level) begin
                                // start edge, first sample half a bit later
                                n_rx_bits  = hduart_pkg::RX_SAMPLES;
                                n_rx_shift = 8'd0;
                                n_timer_on = 1'b1;
                                n_baud_cnt = {1'b0, r_baud[15:1]};
                            end
                            n_prev_rx = i_cmd.rx_level;
                        end
                        hduart_pkg::OP_POLL: begin
                            if (r_rx_count != '0) begin
                                if (r_idle != hduart_pkg::IDLE_COUNT_MAX) begin
                                    n_idle = r_idle + 16'd1;
                                end
                                if (r_idle >= r_timeout) begin
                                    emit_status = 1'b0;
                                    n_rx_count  = '0;
                                    n_dump_idx  = '0;
                                    n_dump_n    = (int'(r_rx_count) > hduart_pkg::MAX_FRAME) ?
                                        hduart_pkg::FRAME_CNT_W'(hduart_pkg::MAX_FRAME) :
                                        hduart_pkg::FRAME_CNT_W'(r_rx_count);
                                    n_state     = S_DUMP_RD;
                                end
                            end
                        end
                        hduart_pkg::OP_LOAD: begin
                            if (!r_tx_on) begin
                                if (r_tx_count < TX_FULL) begin
                                    tx_we      = 1'b1;
                                    n_tx_count = r_tx_count + CW'(1);
                                end
                                if (i_cmd.tx_last) begin
                                    n_tx_index = '0;
                                    n_tx_phase = 4'd0;
                                    n_tx_on    = 1'b1;
                                    n_timer_on = 1'b1;
                                    n_baud_cnt = 16'd0;
                                    n_rx_bits  = 4'd0;
                                end
                                // let the buffer read settle before the next tick
                                n_state = S_LOAD_WAIT1;
                            end
                        end
                        default: ;
                    endcase
                    if (emit_status) begin
                        n_out_valid             = 1'b1;
                        n_out_item.tx_level     = n_line;
                        n_out_item.tx_drive     = r_one_wire ? n_tx_on : 1'b1;
                        n_out_item.busy_res     = n_tx_on;
                        n_out_item.frame_valid  = 1'b0;
                        n_out_item.frame_byte   = 8'd0;
                        n_out_item.frame_last   = 1'b0;
                    end
                end
            end
            S_LOAD_WAIT1: n_state = S_LOAD_WAIT2;
            S_LOAD_WAIT2: n_state = S_RUN;
            S_DUMP_RD:    n_state = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_item.tx_level    = r_line;
                    n_out_item.tx_drive    = r_one_wire ? r_tx_on : 1'b1;
                    n_out_item.busy_res    = r_tx_on;
                    n_out_item.frame_valid = 1'b1;
                    n_out_item.frame_byte  = rx_rdata;
                    n_out_item.frame_last  = ({1'b0, r_dump_idx} + 1'b1) == r_dump_n;
                    n_dump_idx             = r_dump_idx + 1'b1;
                    n_state = n_out_item.frame_last ? S_RUN : S_DUMP_RD;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_baud      <= hduart_pkg::BAUD_DIVISOR_RESET;
            r_timeout   <= hduart_pkg::IDLE_TIMEOUT_RESET;
            r_one_wire  <= 1'b0;
            r_tx_count  <= '0;
            r_tx_index  <= '0;
            r_tx_phase  <= 4'd0;
            r_tx_shift  <= 8'd0;
            r_tx_on     <= 1'b0;
            r_rx_count  <= '0;
            r_rx_bits   <= 4'd0;
            r_rx_shift  <= 8'd0;
            r_idle      <= 16'd0;
            r_baud_cnt  <= 16'd0;
            r_timer_on  <= 1'b0;
            r_prev_rx   <= 1'b1;
            r_line      <= 1'b1;
            r_dump_idx  <= '0;
            r_dump_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_baud      <= n_baud;
            r_timeout   <= n_timeout;
            r_one_wire  <= n_one_wire;
            r_tx_count  <= n_tx_count;
            r_tx_index  <= n_tx_index;
            r_tx_phase  <= n_tx_phase;
            r_tx_shift  <= n_tx_shift;
            r_tx_on     <= n_tx_on;
            r_rx_count  <= n_rx_count;
            r_rx_bits   <= n_rx_bits;
            r_rx_shift  <= n_rx_shift;
            r_idle      <= n_idle;
            r_baud_cnt  <= n_baud_cnt;
            r_timer_on  <= n_timer_on;
            r_prev_rx   <= n_prev_rx;
            r_line      <= n_line;
            r_dump_idx  <= n_dump_idx;
            r_dump_n    <= n_dump_n;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    hduart_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_count[AW-1:0]),
        .i_wdata (i_cmd.tx_byte),
        .i_raddr (r_tx_index[AW-1:0]),
        .o_rdata (tx_rdata)
    );

    hduart_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_count),
        .i_wdata (rx_wdata),
        .i_raddr (AW'(r_dump_idx)),
        .o_rdata (rx_rdata)
    );

endmodule

`default_nettype wire

/* tb/uart_frame_check.sv */
`timescale 1ns / 100ps

module uart_frame_check
    import hduart_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out_item,
    output int                         o_pending,
    output int                         o_fail_count
);

    logic [15:0] baud_div;
    logic [15:0] idle_limit;
    logic        one_wire;

    logic [7:0]  tx_mem [DEPTH];
    int          tx_fill;
    int          tx_pos;
    int          tx_step;
    logic [7:0]  tx_sr;
    logic        tx_busy;
    logic        line_lvl;

    logic [7:0]  rx_mem [DEPTH];
    int          rx_fill;
    int          rx_left;
    logic [7:0]  rx_sr;
    logic        rx_prev;
    int          idle_polls;

    logic [15:0] baud_cnt;
    logic        timer_run;

    t_out_item   frame_q [$];
    t_out_item   want;
    int          n_bad = 0;
    int          n_wait = 0;

    assign o_pending    = n_wait;
    assign o_fail_count = n_bad;

    function automatic t_out_item make_result(logic vld, logic [7:0] b, logic lst);
        t_out_item r;
        r.tx_level    = line_lvl;
        r.tx_drive    = one_wire ? tx_busy : 1'b1;
        r.busy_res    = tx_busy;
        r.frame_valid = vld;
        r.frame_byte  = b;
        r.frame_last  = lst;
        return r;
    endfunction

    function automatic void shift_out_bit();
        if (tx_step == 0) begin
            line_lvl = 1'b0;
            tx_sr    = (tx_pos < DEPTH) ? tx_mem[tx_pos] : 8'h00;
            tx_pos++;
            tx_step  = 1;
        end else if (tx_step < 9) begin
            line_lvl = tx_sr[0];
            tx_sr    = tx_sr >> 1;
            tx_step++;
        end else begin
            line_lvl = 1'b1;
            tx_step  = 0;
            if (tx_pos >= tx_fill) begin
                tx_busy   = 1'b0;
                timer_run = 1'b0;
                tx_fill   = 0;
                tx_pos    = 0;
            end
        end
    endfunction

    function automatic void sample_bit(logic lvl);
        rx_sr = {lvl, rx_sr[7:1]};
        if (rx_left > 0)
            rx_left--;
        if (rx_left == 0) begin
            timer_run  = 1'b0;
            idle_polls = 0;
            rx_mem[rx_fill % DEPTH] = rx_sr;
            rx_fill++;
            if (rx_fill >= DEPTH)
                rx_fill = 0;
        end
    endfunction

    function automatic void clock_tick(logic lvl);
        if (timer_run) begin
            baud_cnt = baud_cnt + 16'd1;
            if (baud_cnt >= baud_div) begin
                baud_cnt = 16'd0;
                if (tx_busy)
                    shift_out_bit();
                else
                    sample_bit(lvl);
            end
        end else if (!tx_busy && rx_left == 0 && rx_prev && !lvl) begin
            rx_left   = 9;
            rx_sr     = 8'h00;
            timer_run = 1'b1;
            baud_cnt  = baud_div >> 1;
        end
        rx_prev = lvl;
    endfunction

    function automatic void predict_item(t_in_item it);
        int   n;
        logic dump;
        dump = 1'b0;
        case (t_op'(it.func))
            OP_TICK: begin
                clock_tick(it.rx_level);
            end
            OP_POLL: begin
                if (rx_fill != 0) begin
                    dump = (idle_polls >= idle_limit);
                    if (idle_polls < IDLE_COUNT_MAX)
                        idle_polls++;
                    if (dump) begin
                        n = (rx_fill > MAX_FRAME) ? MAX_FRAME : rx_fill;
                        rx_fill = 0;
                        for (int i = 0; i < n; i++)
                            frame_q.push_back(make_result(1'b1, rx_mem[i % DEPTH], i + 1 == n));
                    end
                end
            end
            OP_LOAD: begin
                if (!tx_busy) begin
                    if (tx_fill < DEPTH) begin
                        tx_mem[tx_fill] = it.tx_byte;
                        tx_fill++;
                    end
                    if (it.tx_last) begin
                        tx_pos    = 0;
                        tx_step   = 0;
                        tx_busy   = 1'b1;
                        timer_run = 1'b1;
                        baud_cnt  = 16'd0;
                        rx_left   = 0;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!dump)
            frame_q.push_back(make_result(1'b0, 8'h00, 1'b0));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            baud_div   = BAUD_DIVISOR_RESET;
            idle_limit = IDLE_TIMEOUT_RESET;
            one_wire   = 1'b0;
            tx_fill    = 0;
            tx_pos     = 0;
            tx_step    = 0;
            tx_sr      = 8'h00;
            tx_busy    = 1'b0;
            line_lvl   = 1'b1;
            rx_fill    = 0;
            rx_left    = 0;
            rx_sr      = 8'h00;
            rx_prev    = 1'b1;
            idle_polls = 0;
            baud_cnt   = 16'd0;
            timer_run  = 1'b0;
            frame_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BAUD_DIVISOR:    baud_div   = i_cfg_data;
                    CFG_IDLE_TIMEOUT_MS: idle_limit = i_cfg_data;
                    CFG_ONE_WIRE_MODE:   one_wire   = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_item(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result item %h at %0t", i_out_item, $realtime);
                end else begin
                    want = frame_q.pop_front();
                    if (want.tx_level !== i_out_item.tx_level
                            || want.tx_drive !== i_out_item.tx_drive
                            || want.busy_res !== i_out_item.busy_res
                            || want.frame_valid !== i_out_item.frame_valid
                            || want.frame_byte !== i_out_item.frame_byte
                            || want.frame_last !== i_out_item.frame_last) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("mismatch at %0t: expected lvl=%b drv=%b busy=%b vld=%b byte=%h last=%b",
                                $realtime, want.tx_level, want.tx_drive, want.busy_res,
                                want.frame_valid, want.frame_byte, want.frame_last);
                            $display("    actual lvl=%b drv=%b busy=%b vld=%b byte=%h last=%b",
                                i_out_item.tx_level, i_out_item.tx_drive, i_out_item.busy_res,
                                i_out_item.frame_valid, i_out_item.frame_byte,
                                i_out_item.frame_last);
                        end
                    end
                end
            end
        end
        n_wait = frame_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import hduart_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_OPS   = 72;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_BAUD_DIVISOR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item  = '0;
    logic                  out_stall = 1'b0;
    wire logic             in_stall;
    wire logic             out_valid;
    t_out_item             out_item;

    int pending;
    int fails;

    int cur_div    = BAUD_DIVISOR_RESET;
    int cur_tmo    = IDLE_TIMEOUT_RESET;
    int tx_held    = 0;
    bit no_gaps    = 1'b0;
    int stall_left = 0;
    int stall_pick;
    int cycle_cnt  = 0;

    half_duplex_uart_frame_engine_core #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    uart_frame_check #(
        .DEPTH(DEPTH)
    ) u_frame_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_pending   (pending),
        .o_fail_count(fails)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver back-pressure: short bursts, a few long holds, quiet stretches
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end else if (stall_pick < 90) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else if (stall_pick < 97) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end else begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(100, 300);
            end
        end
    end

    function automatic int bit_ticks();
        return (cur_div < 2) ? 1 : cur_div;
    endfunction

    task automatic push_item(input t_op op, input logic lvl, input logic [7:0] b,
                             input logic lst);
        int       gap;
        int       r;
        t_in_item it;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70)
            gap = 0;
        else if (r < 96)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        it.func     = op;
        it.rx_level = lvl;
        it.tx_byte  = b;
        it.tx_last  = lst;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic tick(input logic lvl);
        push_item(OP_TICK, lvl, 8'($urandom), 1'($urandom));
    endtask

    task automatic poll();
        push_item(OP_POLL, 1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic load(input logic [7:0] b, input logic lst);
        push_item(OP_LOAD, 1'($urandom), b, lst);
        if (tx_held < DEPTH)
            tx_held++;
    endtask

    task automatic flush_line();
        repeat (11 * bit_ticks() + 2) tick(1'b1);
    endtask

    // run the transmitter to its end, with ignored loads and polls mixed in
    task automatic drain_tx();
        int n;
        n = tx_held * 10 * bit_ticks() + 3;
        tx_held = 0;
        for (int k = 0; k < n; k++) begin
            if (k < n - 4 && $urandom_range(0, 24) == 0)
                push_item(OP_LOAD, 1'($urandom), 8'($urandom), 1'($urandom));
            else if ($urandom_range(0, 24) == 0)
                poll();
            tick(1'b1);
        end
    endtask

    task automatic tx_frame(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
                tick(1'b1);
            load(8'($urandom), i == n - 1);
        end
        drain_tx();
    endtask

    task automatic rx_byte(input logic [7:0] b, input bit polls_ok);
        logic lvl;
        for (int k = 0; k < 10; k++) begin
            lvl = (k == 0) ? 1'b0 : (k == 9) ? 1'b1 : b[k-1];
            repeat (bit_ticks()) begin
                if (polls_ok && $urandom_range(0, 29) == 0)
                    poll();
                tick(lvl);
            end
        end
        repeat ($urandom_range(0, 2)) tick(1'b1);
    endtask

    task automatic end_frame();
        repeat ((cur_tmo <= 16) ? cur_tmo + 1 : 3) poll();
    endtask

    task automatic rx_frame(input int n, input bit polls_ok);
        repeat (n) rx_byte(8'($urandom), polls_ok);
        end_frame();
    endtask

    // transmit request lands in the middle of an incoming byte
    task automatic collide();
        tick(1'b1);
        repeat (bit_ticks()) tick(1'b0);
        repeat ($urandom_range(0, 7) * bit_ticks()) tick(1'($urandom));
        load(8'($urandom), 1'b1);
        drain_tx();
    endtask

    task automatic noise(input int n);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: tick(1'($urandom));
                1: poll();
                2: load(8'($urandom), 1'b0);
                default: push_item(OP_NOP, 1'($urandom), 8'($urandom), 1'($urandom));
            endcase
        end
        flush_line();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] div, input logic [15:0] tmo, input logic ow);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BAUD_DIVISOR;
        cfg_data <= div;
        @(posedge clk);
        cfg_idx  <= CFG_IDLE_TIMEOUT_MS;
        cfg_data <= tmo;
        @(posedge clk);
        cfg_idx  <= CFG_ONE_WIRE_MODE;
        cfg_data <= {15'd0, ow};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_div = div;
        cur_tmo = tmo;
    endtask

    task automatic random_phase();
        int ops;
        int r;
        int n;
        ops = 0;
        while (ops < PHASE_OPS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                n = $urandom_range(1, 4);
                rx_frame(n, $urandom_range(0, 3) == 0);
                ops += n;
            end else if (r < 60) begin
                n = $urandom_range(1, 4);
                tx_frame(n);
                ops += n;
            end else if (r < 75) begin
                n = $urandom_range(2, 10);
                noise(n);
                ops += n;
            end else if (r < 86) begin
                collide();
                ops += 2;
            end else if (r < 98) begin
                poll();
                ops++;
            end else if (r < 99) begin
                rx_frame(33, 1'b0);
                ops += 33;
            end else begin
                tx_frame(34);
                ops += 34;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration
        poll();
        push_item(OP_NOP, 1'b1, 8'hFF, 1'b1);
        tick(1'b1);

        settle();
        set_config(16'd2, 16'd0, 1'b1);
        push_item(OP_NOP, 1'b0, 8'h00, 1'b0);
        poll();
        load(8'h00, 1'b0);
        load(8'hFF, 1'b1);
        push_item(OP_LOAD, 1'b0, 8'h81, 1'b1);
        drain_tx();
        tick(1'b1);
        rx_byte(8'h00, 1'b0);
        rx_byte(8'hFF, 1'b0);
        rx_byte(8'h5A, 1'b0);
        poll();
        poll();
        collide();

        settle();
        set_config(16'hFFFF, 16'hFFFF, 1'b0);
        poll();
        push_item(OP_NOP, 1'b0, 8'hA5, 1'b0);
        tick(1'b1);
        load(8'h3C, 1'b0);

        // full transmit buffer and receive count wrap at the fastest bit rate
        settle();
        set_config(16'd1, 16'd2, 1'b1);
        tx_frame(34);
        rx_frame(33, 1'b0);
        rx_frame(2, 1'b1);

        settle();
        set_config(16'd0, 16'd1, 1'b0);
        rx_frame(2, 1'b0);
        tx_frame(1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            set_config(16'($urandom_range(2, 8)), (p == 3) ? 16'hFFFF : 16'($urandom_range(0, 6)),
                       1'($urandom));
            no_gaps = ($urandom_range(0, 3) == 0);
            random_phase();
        end

        settle();
        repeat (20) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
